>>> rtl/mkpd_pkg.sv
package mkpd_pkg;

    // per-key phase codes
    localparam logic [1:0] PH_RELEASED = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_PRESSED  = 2'd2;

    // reported event kinds
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPAN    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KMAP_LO = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KMAP_HI = 2'd2;

    localparam logic [31:0] SPAN_RESET = 32'd10000;
    localparam int KMAP_KEYS = 16;

    typedef struct packed {
        logic load;      // capture the input transaction, clear event
        logic rd_first;  // read phase of column 0
        logic step;      // process one column, prefetch the next
        logic emit;      // load the result register, advance the row
    } mkpd_cmd_t;

    typedef struct packed {
        logic last_col;
        logic out_busy;
    } mkpd_status_t;

endpackage

>>> rtl/matrix_keypad_scanner_debounce.sv
// no transaction is accepted until the last one has passed the first phase read, the
//   column walk and the emit step, which waits while the result register is stalled;
//   the walk handles one key per cycle via the registered read of the key phase store
// in_stall is low only while no scan tick is in progress
// reset (rst_n, async, active low): all keys released, stamps, row and held codes
//   cleared, debounce_span 10000, keymaps zero, result register empty
module matrix_keypad_scanner_debounce #(
    parameter int ROWS     = 4,
    parameter int COLS     = 4,
    parameter int HELD_MAX = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [31:0]                      time_now,
    input  logic [3:0]                       col_active,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       event_kind,
    output logic [7:0]                       first_code,
    output logic [7:0]                       second_code,
    output logic [1:0]                       held_total,
    output logic [31:0]                      trigger_stamp,
    output logic                             press_flag,
    output logic [1:0]                       row_scanned,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mkpd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                      cfg_data
);

    mkpd_pkg::mkpd_cmd_t    cmd;
    mkpd_pkg::mkpd_status_t status;

    assign cfg_ready = 1'b1;

    mkpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mkpd_datapath #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .HELD_MAX (HELD_MAX)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .time_now      (time_now),
        .col_active    (col_active),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_kind    (event_kind),
        .first_code    (first_code),
        .second_code   (second_code),
        .held_total    (held_total),
        .trigger_stamp (trigger_stamp),
        .press_flag    (press_flag),
        .row_scanned   (row_scanned)
    );

endmodule

>>> rtl/mkpd_ctrl.sv
module mkpd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  mkpd_pkg::mkpd_status_t status,
    output mkpd_pkg::mkpd_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_COL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_first = 1'b1;
                state_next   = S_COL;
            end
            S_COL:
            begin
                cmd.step = 1'b1;
                if (status.last_col)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !status.out_busy)
        else $error("result register overwritten while stalled");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_READ)
        else $error("column walk did not start after load");

endmodule

>>> rtl/mkpd_datapath.sv
module mkpd_datapath #(
    parameter int ROWS     = 4,
    parameter int COLS     = 4,
    parameter int HELD_MAX = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mkpd_pkg::mkpd_cmd_t                 cmd,
    output mkpd_pkg::mkpd_status_t              status,
    input  logic [31:0]                         time_now,
    input  logic [3:0]                          col_active,
    input  logic                                cfg_valid,
    input  logic [mkpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [63:0]                         cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          event_kind,
    output logic [7:0]                          first_code,
    output logic [7:0]                          second_code,
    output logic [1:0]                          held_total,
    output logic [31:0]                         trigger_stamp,
    output logic                                press_flag,
    output logic [1:0]                          row_scanned
);

    localparam int NKEYS = ROWS * COLS;
    localparam int POS_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CNT_W = $clog2(HELD_MAX + 1);

    // configuration
    logic [31:0] span_reg;
    logic [63:0] kmap_low_reg;
    logic [63:0] kmap_high_reg;

    // captured transaction
    logic [31:0] now_reg;
    logic [3:0]  cols_reg;

    // scan state
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_reg;
    logic [31:0]      dstamp_reg;
    logic [31:0]      dstamp_next;
    logic [31:0]      pstamp_reg;
    logic [31:0]      pstamp_next;
    logic             pmark_reg;
    logic             pmark_next;
    logic [1:0]       event_reg;
    logic [1:0]       event_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       buf_reg [HELD_MAX];
    logic [7:0]       buf_next [HELD_MAX];

    // phase store, invalid entries read as released
    logic [1:0]       phase_mem [NKEYS];
    logic [NKEYS-1:0] phase_vld_reg;
    logic [1:0]       rd_data_reg;
    logic             rd_vld_reg;
    logic             rd_en;
    logic [COL_W-1:0] rd_col;
    logic [POS_W-1:0] rd_addr;
    logic [POS_W-1:0] pos;
    logic [7:0]       pos_ext;

    // result register
    logic        out_valid_reg;
    logic [1:0]  out_event_reg;
    logic [7:0]  out_first_reg;
    logic [7:0]  out_second_reg;
    logic [1:0]  out_total_reg;
    logic [31:0] out_stamp_reg;
    logic        out_flag_reg;
    logic [1:0]  out_row_reg;

    logic [15:0][7:0] kmap_all;
    logic [7:0]       code;
    logic [7:0]       cols_ext;
    logic             act;
    logic [1:0]       ph_cur;
    logic [1:0]       ph_new;
    logic [31:0]      elapsed;
    logic             timeout;
    logic [CNT_W-1:0] top;
    logic [7:0]       top_code;
    logic [7:0]       slot1_code;

    assign status.last_col = (col_reg == COL_W'(COLS - 1));
    assign status.out_busy = out_valid_reg && out_stall;

    assign pos     = POS_W'(row_reg) * POS_W'(COLS) + POS_W'(col_reg);
    assign pos_ext = 8'(pos);
    assign kmap_all = {kmap_high_reg, kmap_low_reg};
    assign code     = (pos_ext < 8'(mkpd_pkg::KMAP_KEYS)) ? kmap_all[pos_ext[3:0]] : 8'd0;

    // column bits beyond the physical four read as inactive
    assign cols_ext = 8'(cols_reg);
    assign act      = cols_ext[3'(col_reg)];
    assign ph_cur   = rd_vld_reg ? rd_data_reg : mkpd_pkg::PH_RELEASED;
    assign elapsed  = now_reg - dstamp_reg;
    assign timeout  = elapsed > span_reg;

    assign rd_en   = cmd.rd_first || (cmd.step && !status.last_col);
    assign rd_col  = cmd.rd_first ? '0 : col_reg + COL_W'(1);
    assign rd_addr = POS_W'(row_reg) * POS_W'(COLS) + POS_W'(rd_col);

    assign row_next = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + ROW_W'(1);

    always_comb
    begin
        top        = count_reg - CNT_W'(1);
        top_code   = 8'd0;
        slot1_code = 8'd0;
        for (int i = 0; i < HELD_MAX; i++)
        begin
            if (CNT_W'(i) == top)
                top_code = buf_reg[i];
            if (i == 1)
                slot1_code = buf_reg[i];
        end
    end

    always_comb
    begin
        dstamp_next = dstamp_reg;
        pstamp_next = pstamp_reg;
        pmark_next  = pmark_reg;
        event_next  = event_reg;
        count_next  = count_reg;
        buf_next    = buf_reg;
        ph_new      = ph_cur;
        if (cmd.load)
            event_next = mkpd_pkg::EV_NONE;
        if (cmd.step)
        begin
            if (act)
            begin
                if (ph_cur == mkpd_pkg::PH_RELEASED)
                begin
                    ph_new      = mkpd_pkg::PH_DEBOUNCE;
                    dstamp_next = now_reg | 32'd1;
                end
                else if (ph_cur == mkpd_pkg::PH_DEBOUNCE && timeout)
                begin
                    ph_new      = mkpd_pkg::PH_PRESSED;
                    event_next  = mkpd_pkg::EV_PRESS;
                    pmark_next  = 1'b1;
                    pstamp_next = now_reg | 32'd1;
                    // a full buffer still reports the press
                    if (count_reg < CNT_W'(HELD_MAX))
                    begin
                        for (int i = 0; i < HELD_MAX; i++)
                        begin
                            if (CNT_W'(i) == count_reg)
                                buf_next[i] = code;
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            else if (ph_cur == mkpd_pkg::PH_PRESSED || ph_cur == mkpd_pkg::PH_DEBOUNCE)
            begin
                ph_new      = mkpd_pkg::PH_RELEASED;
                event_next  = mkpd_pkg::EV_RELEASE;
                dstamp_next = now_reg | 32'd1;
                pstamp_next = 32'd0;
                pmark_next  = 1'b0;
                if (count_reg != '0)
                begin
                    count_next = top;
                    // a top code above slot 0 moves to slot 0 when it is not the released key
                    for (int i = 0; i < HELD_MAX; i++)
                    begin
                        if (CNT_W'(i) == top)
                            buf_next[i] = 8'd0;
                        else if (i == 0 && top_code != code)
                            buf_next[i] = top_code;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg      <= mkpd_pkg::SPAN_RESET;
            kmap_low_reg  <= 64'd0;
            kmap_high_reg <= 64'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mkpd_pkg::CFG_SPAN:    span_reg      <= cfg_data[31:0];
                mkpd_pkg::CFG_KMAP_LO: kmap_low_reg  <= cfg_data;
                mkpd_pkg::CFG_KMAP_HI: kmap_high_reg <= cfg_data;
                default:               span_reg      <= span_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg  <= time_now;
            cols_reg <= col_active;
        end
        if (cmd.step)
            phase_mem[pos] <= ph_new;
        if (rd_en)
            rd_data_reg <= phase_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_vld_reg <= '0;
            rd_vld_reg    <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            dstamp_reg    <= 32'd0;
            pstamp_reg    <= 32'd0;
            pmark_reg     <= 1'b0;
            event_reg     <= mkpd_pkg::EV_NONE;
            count_reg     <= '0;
            for (int i = 0; i < HELD_MAX; i++)
                buf_reg[i] <= 8'd0;
        end
        else
        begin
            if (cmd.step)
                phase_vld_reg[pos] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= phase_vld_reg[rd_addr];
            if (cmd.rd_first)
                col_reg <= '0;
            else if (cmd.step && !status.last_col)
                col_reg <= col_reg + COL_W'(1);
            if (cmd.emit)
                row_reg <= row_next;
            dstamp_reg <= dstamp_next;
            pstamp_reg <= pstamp_next;
            pmark_reg  <= pmark_next;
            event_reg  <= event_next;
            count_reg  <= count_next;
            buf_reg    <= buf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_event_reg  <= event_reg;
            out_first_reg  <= buf_reg[0];
            out_second_reg <= slot1_code;
            out_total_reg  <= 2'(count_reg);
            out_stamp_reg  <= pstamp_reg;
            out_flag_reg   <= pmark_reg;
            out_row_reg    <= 2'(row_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = out_event_reg;
    assign first_code    = out_first_reg;
    assign second_code   = out_second_reg;
    assign held_total    = out_total_reg;
    assign trigger_stamp = out_stamp_reg;
    assign press_flag    = out_flag_reg;
    assign row_scanned   = out_row_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HELD_MAX))
        else $error("held code count above buffer depth");

    a_mark_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        pmark_reg == (pstamp_reg != 32'd0))
        else $error("press mark and press stamp disagree");

    a_dstamp_odd: assert property (@(posedge clk) disable iff (!rst_n)
        dstamp_reg == 32'd0 || dstamp_reg[0])
        else $error("debounce stamp stored with bit 0 clear");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg && out_event_reg != 2'd3)
        else $error("bad result after emit");

endmodule
